// File: rtl/core/gka_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gka_pkg: shared types and constants of the group key id assigner
// Table sizes, derived widths, status codes and the hash unit handshake.
// ----------------------------------------------------------------------------
package gka_pkg;

	// table sizes (both powers of two)
	localparam int MAX_GROUPS = 1024;
	localparam int HASH_SLOTS = 2048;

	// field widths
	localparam int KEY_W   = 64;
	localparam int GROUP_W = $clog2(MAX_GROUPS);
	localparam int CNT_W   = GROUP_W + 1;
	localparam int SLOT_W  = $clog2(HASH_SLOTS);
	localparam int STAT_W  = 2;

	// multiplicative hash: home slot is bits [32 +: SLOT_W] of key * HASH_C
	localparam logic [KEY_W-1:0] HASH_C = 64'h9E37_79B9_7F4A_7C15;
	localparam int HASH_W = 32 + SLOT_W;
	localparam int LO_W   = (HASH_W + 1) / 2;
	localparam int HI_W   = HASH_W - LO_W;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
	localparam logic [STAT_W-1:0] ST_NULL       = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNASSIGNED = 2'd3;

	// operation codes
	localparam logic OP_CONSUME = 1'b0;
	localparam logic OP_READ    = 1'b1;

	// hash unit request and response
	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] key_bits;
	} hash_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] slot;
	} hash_rsp_t;

	// one hash table slot
	typedef struct packed {
		logic               valid;
		logic [GROUP_W-1:0] group;
		logic [KEY_W-1:0]   key;
	} slot_t;

endpackage
`default_nettype wire

// File: rtl/core/gka_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gka_req_if: request channel of the group key id assigner
// Valid/ready channel carrying one consume or read-back beat.
// ----------------------------------------------------------------------------
interface gka_req_if;
	import gka_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic signed [KEY_W-1:0] key;
	logic                    key_is_null;
	logic [GROUP_W-1:0]      read_index;

	modport source (output valid, op, key, key_is_null, read_index, input ready);
	modport sink (input valid, op, key, key_is_null, read_index, output ready);
endinterface
`default_nettype wire

// File: rtl/core/gka_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gka_rsp_if: result channel of the group key id assigner
// Valid/ready channel carrying one result beat per request beat.
// ----------------------------------------------------------------------------
interface gka_rsp_if;
	import gka_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [GROUP_W-1:0]      grp_id;
	logic                    is_new;
	logic [STAT_W-1:0]       status;
	logic signed [KEY_W-1:0] key_out;

	modport source (output valid, grp_id, is_new, status, key_out, input ready);
	modport sink (input valid, grp_id, is_new, status, key_out, output ready);
endinterface
`default_nettype wire

// File: rtl/core/group_key_id_assigner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Consume rows pass the shared hash multiplier, then a slot read and compare per
// probe step; read-back and null rows skip the hash. One item at a time: a new
// beat is taken only after the previous result has been loaded into the output
// register, which waits while an earlier result is held unaccepted. Reset: a
// clearing pass walks all HASH_SLOTS (2048) slots, one per cycle, before the
// first beat is accepted; the group count is zero.
// ----------------------------------------------------------------------------
// group_key_id_assigner_core: hash group-by table giving dense group ids
// Linear-probing slot table keyed by a multiplicative hash, plus a key store
// indexed by group id for read-back.
// ----------------------------------------------------------------------------
module group_key_id_assigner_core (
	input  logic      clk,
	input  logic      arst_n,
	gka_req_if.sink   req,
	gka_rsp_if.source rsp
);
	import gka_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PRD   = 3'd3;
	localparam logic [2:0] S_PCMP  = 3'd4;
	localparam logic [2:0] S_RDW   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(HASH_SLOTS - 1);
	localparam logic [CNT_W-1:0]  GROUPS_MAX = CNT_W'(MAX_GROUPS);

	logic [2:0]         state_q;
	logic [SLOT_W-1:0]  clr_q;
	logic [SLOT_W-1:0]  pos_q;
	logic [SLOT_W-1:0]  probe_q;
	logic [CNT_W-1:0]   gc_q;
	logic [KEY_W-1:0]   key_q;
	logic               read_ok_q;
	logic [GROUP_W-1:0] ridx_q;

	// pending result
	logic [GROUP_W-1:0] res_gid_q;
	logic               res_new_q;
	logic [STAT_W-1:0]  res_stat_q;
	logic [KEY_W-1:0]   res_key_q;

	// output register
	logic               out_valid_q;
	logic [GROUP_W-1:0] out_gid_q;
	logic               out_new_q;
	logic [STAT_W-1:0]  out_stat_q;
	logic [KEY_W-1:0]   out_key_q;

	// memories
	slot_t              slot_mem [HASH_SLOTS];
	slot_t              slot_rd_q;
	logic [KEY_W-1:0]   kbg_mem [MAX_GROUPS];
	logic [KEY_W-1:0]   kbg_rd_q;

	logic               accept;
	logic               out_load;
	logic               slot_we;
	logic [SLOT_W-1:0]  slot_waddr;
	slot_t              slot_wdata;
	logic               kbg_we;
	logic               hit;
	logic               table_full;
	hash_req_t          hreq;
	hash_rsp_t          hrsp;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign hit        = slot_rd_q.valid && (slot_rd_q.key == key_q);
	assign table_full = (gc_q >= GROUPS_MAX);

	// hash unit
	assign hreq.start    = accept && (req.op == OP_CONSUME) && !req.key_is_null;
	assign hreq.key_bits = req.key[HASH_W-1:0];

	gka_hash_unit u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.hreq   (hreq),
		.hrsp   (hrsp)
	);

	// slot write port: clearing pass or new group insert
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = pos_q;
		slot_wdata = '0;
		kbg_we     = 1'b0;
		if (state_q == S_CLEAR) begin
			slot_we    = 1'b1;
			slot_waddr = clr_q;
		end else if (state_q == S_PCMP && !slot_rd_q.valid && !table_full) begin
			slot_we          = 1'b1;
			slot_wdata.valid = 1'b1;
			slot_wdata.group = gc_q[GROUP_W-1:0];
			slot_wdata.key   = key_q;
			kbg_we           = 1'b1;
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
		if (state_q == S_PRD) slot_rd_q <= slot_mem[pos_q];
	end

	// key store by group id
	always_ff @(posedge clk) begin
		if (kbg_we) kbg_mem[gc_q[GROUP_W-1:0]] <= key_q;
		if (accept) kbg_rd_q <= kbg_mem[req.read_index];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			gc_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (req.op == OP_READ) begin
							state_q <= S_RDW;
						end else if (req.key_is_null) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: if (hrsp.done) state_q <= S_PRD;
				S_PRD:  state_q <= S_PCMP;
				S_PCMP: begin
					if (!slot_rd_q.valid) begin
						if (!table_full) gc_q <= gc_q + 1'b1;
						state_q <= S_DONE;
					end else if (hit || probe_q == LAST_SLOT) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_RDW:  state_q <= S_DONE;
				S_DONE: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload, probe position and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q      <= req.key;
					ridx_q     <= req.read_index;
					read_ok_q  <= (CNT_W'(req.read_index) < gc_q);
					res_gid_q  <= '0;
					res_new_q  <= 1'b0;
					res_stat_q <= ST_NULL;
					res_key_q  <= '0;
				end
			end
			S_HASH: begin
				pos_q   <= hrsp.slot;
				probe_q <= '0;
			end
			S_PCMP: begin
				pos_q   <= pos_q + 1'b1;
				probe_q <= probe_q + 1'b1;
				if (!slot_rd_q.valid) begin
					if (table_full) begin
						res_gid_q  <= '0;
						res_new_q  <= 1'b0;
						res_stat_q <= ST_FULL;
						res_key_q  <= '0;
					end else begin
						res_gid_q  <= gc_q[GROUP_W-1:0];
						res_new_q  <= 1'b1;
						res_stat_q <= ST_OK;
						res_key_q  <= key_q;
					end
				end else if (hit) begin
					res_gid_q  <= slot_rd_q.group;
					res_new_q  <= 1'b0;
					res_stat_q <= ST_OK;
					res_key_q  <= key_q;
				end else begin
					// every slot visited without a match or a free slot
					res_gid_q  <= '0;
					res_new_q  <= 1'b0;
					res_stat_q <= ST_FULL;
					res_key_q  <= '0;
				end
			end
			S_RDW: begin
				res_gid_q  <= ridx_q;
				res_new_q  <= 1'b0;
				res_stat_q <= read_ok_q ? ST_OK : ST_UNASSIGNED;
				res_key_q  <= read_ok_q ? kbg_rd_q : '0;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_gid_q  <= res_gid_q;
			out_new_q  <= res_new_q;
			out_stat_q <= res_stat_q;
			out_key_q  <= res_key_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.grp_id   = out_gid_q;
	assign rsp.is_new   = out_new_q;
	assign rsp.status   = out_stat_q;
	assign rsp.key_out  = out_key_q;

endmodule
`default_nettype wire

// File: rtl/core/gka_hash_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gka_hash_unit: iterative multiplicative hash
// One half-width multiplier is reused for three partial products of the key
// and the hash constant, summed into an accumulator.
// ----------------------------------------------------------------------------
module gka_hash_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  gka_pkg::hash_req_t hreq,
	output gka_pkg::hash_rsp_t hrsp
);
	import gka_pkg::*;

	localparam logic [2:0] H_IDLE = 3'd0;
	localparam logic [2:0] H_LL   = 3'd1;
	localparam logic [2:0] H_HL   = 3'd2;
	localparam logic [2:0] H_LH   = 3'd3;
	localparam logic [2:0] H_LAST = 3'd4;

	localparam logic [HASH_W-1:0] C_BITS = HASH_C[HASH_W-1:0];
	localparam logic [LO_W-1:0]   C_LO   = C_BITS[LO_W-1:0];
	localparam logic [LO_W-1:0]   C_HI   = LO_W'(C_BITS[HASH_W-1:LO_W]);

	logic [2:0]        step_q;
	logic [HASH_W-1:0] key_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] prod_s1;
	logic              add_s1;
	logic              sh_s1;
	logic              done_q;
	logic [LO_W-1:0]   op_a;
	logic [LO_W-1:0]   op_b;
	logic [2*LO_W-1:0] prod;
	logic [HASH_W-1:0] term;

	// operand select for the shared multiplier
	always_comb begin
		unique case (step_q)
			H_LL: begin
				op_a = key_q[LO_W-1:0];
				op_b = C_LO;
			end
			H_HL: begin
				op_a = LO_W'(key_q[HASH_W-1:LO_W]);
				op_b = C_LO;
			end
			H_LH: begin
				op_a = key_q[LO_W-1:0];
				op_b = C_HI;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = (2*LO_W)'(op_a) * (2*LO_W)'(op_b);

	// cross products land one half-word up
	assign term = sh_s1 ? {prod_s1[HASH_W-LO_W-1:0], {LO_W{1'b0}}} : prod_s1;

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= H_IDLE;
			add_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == H_LAST);
			add_s1 <= (step_q == H_LL) || (step_q == H_HL) || (step_q == H_LH);
			unique case (step_q)
				H_IDLE:  if (hreq.start) step_q <= H_LL;
				H_LL:    step_q <= H_HL;
				H_HL:    step_q <= H_LH;
				H_LH:    step_q <= H_LAST;
				default: step_q <= H_IDLE;
			endcase
		end
	end

	// operand capture, product register and accumulator
	always_ff @(posedge clk) begin
		prod_s1 <= prod[HASH_W-1:0];
		sh_s1   <= (step_q != H_LL);
		if (step_q == H_IDLE && hreq.start) begin
			key_q <= hreq.key_bits;
			acc_q <= '0;
		end else if (add_s1) begin
			acc_q <= acc_q + term;
		end
	end

	assign hrsp.done = done_q;
	assign hrsp.slot = acc_q[HASH_W-1:32];

endmodule
`default_nettype wire

// File: tb/group_key_id_assigner_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_key_id_assigner_core_test: self-checking bench for the group id table
// Drives consume, null and read-back beats through the request channel and
// scores every result beat against a software copy of the hash table. A short
// table of directed beats comes first, followed by random traffic under
// several idle and stall mixes and a short tail of mixed beats.
// ----------------------------------------------------------------------------
module group_key_id_assigner_core_test;
	import gka_pkg::*;

	localparam logic [KEY_W-1:0] GOLDEN_MUL  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [KEY_W-1:0] KEY_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_MIN     = 64'h8000_0000_0000_0000;
	localparam logic [KEY_W-1:0] KEY_NEG1    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int               DIRECTED_N  = 23;
	localparam int               HOLD_CYCLES = 400;

	typedef struct packed {
		logic               op;
		logic [KEY_W-1:0]   key;
		logic               key_is_null;
		logic [GROUP_W-1:0] read_index;
	} row_beat_t;

	typedef struct packed {
		logic [GROUP_W-1:0] grp_id;
		logic               is_new;
		logic [STAT_W-1:0]  status;
		logic [KEY_W-1:0]   key_out;
	} group_result_t;

	typedef struct packed {
		row_beat_t     beat;
		logic          typed;
		group_result_t result;
	} directed_row_t;

	logic clk;
	logic arst_n;

	gka_req_if req ();
	gka_rsp_if rsp ();

	group_key_id_assigner_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow copy of the hash table and the id store
	bit                 slot_used    [HASH_SLOTS];
	logic [KEY_W-1:0]   slot_key     [HASH_SLOTS];
	logic [GROUP_W-1:0] slot_group   [HASH_SLOTS];
	logic [KEY_W-1:0]   key_of_group [MAX_GROUPS];
	int                 groups_used = 0;

	group_result_t    expected_results [$];
	logic [KEY_W-1:0] seen_keys [$];
	logic [KEY_W-1:0] family_base [8];
	directed_row_t    directed_rows [DIRECTED_N];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_request   = 1'b0;

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// find the key in the shadow table or give it the next dense id
	function automatic group_result_t lookup_or_assign(input row_beat_t b);
		group_result_t    r;
		logic [KEY_W-1:0] prod;
		int unsigned      pos;
		r = '0;
		if (b.op == OP_READ) begin
			r.grp_id = b.read_index;
			if (int'(b.read_index) < groups_used) begin
				r.status  = ST_OK;
				r.key_out = key_of_group[b.read_index];
			end else begin
				r.status = ST_UNASSIGNED;
			end
			return r;
		end
		if (b.key_is_null) begin
			r.status = ST_NULL;
			return r;
		end
		prod = b.key * GOLDEN_MUL;
		pos  = int'(prod[32 +: SLOT_W]);
		for (int n = 0; n < HASH_SLOTS; n++) begin
			if (!slot_used[pos]) begin
				if (groups_used >= MAX_GROUPS)
					break;
				slot_used[pos]            = 1'b1;
				slot_key[pos]             = b.key;
				slot_group[pos]           = GROUP_W'(groups_used);
				key_of_group[groups_used] = b.key;
				r.grp_id   = GROUP_W'(groups_used);
				r.is_new   = 1'b1;
				r.status   = ST_OK;
				r.key_out  = b.key;
				groups_used++;
				return r;
			end
			if (slot_key[pos] == b.key) begin
				r.grp_id   = slot_group[pos];
				r.status   = ST_OK;
				r.key_out  = b.key;
				return r;
			end
			pos = (pos + 1) % HASH_SLOTS;
		end
		r.status = ST_FULL;
		return r;
	endfunction

	// random beat: reads, null rows, repeats of known keys, else a new key
	function automatic row_beat_t random_row(input int read_pct, input int null_pct,
			input int known_pct);
		row_beat_t b;
		int        pick;
		b.op          = OP_CONSUME;
		b.key         = {$urandom, $urandom};
		b.key_is_null = 1'b0;
		b.read_index  = GROUP_W'($urandom_range(MAX_GROUPS - 1));
		pick          = $urandom_range(99);
		if (pick < read_pct) begin
			b.op          = OP_READ;
			b.key_is_null = 1'($urandom_range(1));
			if ($urandom_range(9) < 7 && groups_used > 0)
				b.read_index = GROUP_W'($urandom_range(groups_used - 1));
		end else if (pick < read_pct + null_pct) begin
			b.key_is_null = 1'b1;
		end else if (pick < read_pct + null_pct + known_pct && seen_keys.size() > 0) begin
			b.key = seen_keys[$urandom_range(seen_keys.size() - 1)];
		end else begin
			case ($urandom_range(9))
				// keys that differ only above bit 42 share a home slot
				0, 1, 2: b.key = family_base[$urandom_range(7)]
						+ (64'($urandom_range(31)) << 43);
				3, 4: b.key = 64'($urandom_range(2000)) - 64'd1000;
				default: ;
			endcase
		end
		return b;
	endfunction

	// offer one beat, wait for the handshake, then queue its expected result
	task automatic send_row(input row_beat_t b, input bit typed, input group_result_t fixed_res);
		group_result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.op          <= b.op;
		req.key         <= b.key;
		req.key_is_null <= b.key_is_null;
		req.read_index  <= b.read_index;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		pred = lookup_or_assign(b);
		if (pred.is_new)
			seen_keys.insert(seen_keys.size(), b.key);
		expected_results.insert(expected_results.size(), typed ? fixed_res : pred);
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		int  hold_left;
		bit  hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		rsp.ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// score every result beat against the oldest expectation
	initial begin
		group_result_t want;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat: grp_id %0d status %0d",
						rsp.grp_id, rsp.status);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.grp_id !== want.grp_id) begin
						$error("grp_id: expected %0d, got %0d", want.grp_id, rsp.grp_id);
						mismatch_count++;
					end
					if (rsp.is_new !== want.is_new) begin
						$error("is_new: expected %0d, got %0d", want.is_new, rsp.is_new);
						mismatch_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.key_out !== want.key_out) begin
						$error("key_out: expected %h, got %h", want.key_out, rsp.key_out);
						mismatch_count++;
					end
				end
			end
		end
	end

	// run limit
	initial begin
		#4_000_000;
		$display("group_key_id_assigner_core_test: errors");
		$finish;
	end

	// main sequence
	initial begin
		int send_idle_by_phase [4];
		int recv_stall_by_phase [4];
		send_idle_by_phase  = '{0, 82, 0, 27};
		recv_stall_by_phase = '{0, 0, 82, 27};

		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.op          = OP_CONSUME;
		req.key         = '0;
		req.key_is_null = 1'b0;
		req.read_index  = '0;
		foreach (family_base[i])
			family_base[i] = {$urandom, $urandom};

		// key 0, KEY_MIN and multiples of 2^43 all hash to slot zero
		directed_rows = '{
			'{'{OP_READ,    64'd0,    1'b0, 10'd0},    1'b1, '{10'd0,    1'b0, ST_UNASSIGNED, 64'd0}},
			'{'{OP_READ,    KEY_NEG1, 1'b1, 10'd1023}, 1'b1, '{10'd1023, 1'b0, ST_UNASSIGNED, 64'd0}},
			'{'{OP_CONSUME, KEY_MAX,  1'b1, 10'd1023}, 1'b1, '{10'd0,    1'b0, ST_NULL, 64'd0}},
			'{'{OP_CONSUME, 64'd0,    1'b0, 10'd0},    1'b1, '{10'd0,    1'b1, ST_OK, 64'd0}},
			'{'{OP_CONSUME, KEY_MIN,  1'b0, 10'd1023}, 1'b1, '{10'd1,    1'b1, ST_OK, KEY_MIN}},
			'{'{OP_CONSUME, KEY_MAX,  1'b0, 10'd0},    1'b1, '{10'd2,    1'b1, ST_OK, KEY_MAX}},
			'{'{OP_CONSUME, KEY_NEG1, 1'b0, 10'd0},    1'b1, '{10'd3,    1'b1, ST_OK, KEY_NEG1}},
			'{'{OP_CONSUME, 64'd0,    1'b0, 10'd1023}, 1'b1, '{10'd0,    1'b0, ST_OK, 64'd0}},
			'{'{OP_CONSUME, KEY_MAX,  1'b0, 10'd0},    1'b1, '{10'd2,    1'b0, ST_OK, KEY_MAX}},
			'{'{OP_READ,    64'd0,    1'b0, 10'd0},    1'b1, '{10'd0,    1'b0, ST_OK, 64'd0}},
			'{'{OP_READ,    KEY_NEG1, 1'b1, 10'd1},    1'b1, '{10'd1,    1'b0, ST_OK, KEY_MIN}},
			'{'{OP_READ,    64'd0,    1'b0, 10'd2},    1'b1, '{10'd2,    1'b0, ST_OK, KEY_MAX}},
			'{'{OP_READ,    64'd0,    1'b0, 10'd3},    1'b1, '{10'd3,    1'b0, ST_OK, KEY_NEG1}},
			'{'{OP_READ,    64'd0,    1'b0, 10'd4},    1'b1, '{10'd4,    1'b0, ST_UNASSIGNED, 64'd0}},
			'{'{OP_CONSUME, 64'd0,    1'b1, 10'd0},    1'b1, '{10'd0,    1'b0, ST_NULL, 64'd0}},
			'{'{OP_CONSUME, 64'd1 << 43, 1'b0, 10'd0}, 1'b0, '0},
			'{'{OP_CONSUME, 64'd2 << 43, 1'b0, 10'd0}, 1'b0, '0},
			'{'{OP_CONSUME, 64'd1 << 43, 1'b0, 10'd0}, 1'b0, '0},
			'{'{OP_CONSUME, 64'h5555_5555_5555_5555, 1'b0, 10'h2AA}, 1'b0, '0},
			'{'{OP_CONSUME, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 10'h155}, 1'b0, '0},
			'{'{OP_CONSUME, KEY_MIN | (64'd3 << 43), 1'b0, 10'd0},  1'b0, '0},
			'{'{OP_READ,    64'd0,    1'b0, 10'd5},    1'b0, '0},
			'{'{OP_READ,    64'd0,    1'b0, 10'd1023}, 1'b1, '{10'd1023, 1'b0, ST_UNASSIGNED, 64'd0}}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[i])
			send_row(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);

		// random traffic under each idle mix; the first mix also holds off the receiver
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_idle_by_phase[ph];
			recv_stall_pct = recv_stall_by_phase[ph];
			if (ph == 0)
				hold_request = 1'b1;
			repeat (150)
				send_row(random_row(15, 10, 30), 1'b0, '0);
		end

		// short tail of reads, nulls, known keys and new keys
		send_idle_pct  = 27;
		recv_stall_pct = 27;
		repeat (30)
			send_row(random_row(40, 10, 30), 1'b0, '0);
		req.valid <= 1'b0;

		// drain
		recv_stall_pct = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (mismatch_count == 0)
			$display("group_key_id_assigner_core_test: clean");
		else
			$display("group_key_id_assigner_core_test: errors");
		$finish;
	end

endmodule

// File: group_key_id_assigner_core.f
rtl/core/gka_pkg.sv
rtl/core/gka_req_if.sv
rtl/core/gka_rsp_if.sv
rtl/core/gka_hash_unit.sv
rtl/core/group_key_id_assigner_core.sv
tb/group_key_id_assigner_core_test.sv
